@@ rtl/tcfe_pkg.sv @@
// ============================================================================
// tcfe_pkg: shared types and constants of the tile cache
// Transaction payloads, scan feed and scan status types, and the fixed
// coordinate and distance widths of the tile directory.
// ============================================================================
`default_nettype none

package tcfe_pkg;

	// Grid of 64 by 64 tiles: a center coordinate is valid when the bits
	// from GRID_W up are zero.
	localparam int GRID_W = 6;
	// Stored coordinates are biased by one so that -1..64 fit unsigned.
	localparam int COORD_W = 7;
	// Manhattan distance of two biased coordinates.
	localparam int DIST_W = COORD_W + 1;
	// Width of the slot field of a result.
	localparam int SLOT_W = 4;
	// Neighborhood is three by three; the counters run 0..2.
	localparam int NEIGHBOUR_SPAN = 3;
	localparam logic [1:0] SPAN_LAST = 2'(NEIGHBOUR_SPAN - 1);

	localparam logic KIND_ENTER = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic              kind;
		logic signed [7:0] centre_x;
		logic signed [7:0] centre_z;
	} cmd_t;

	typedef struct packed {
		logic signed [7:0]  tile_x;
		logic signed [7:0]  tile_z;
		logic [SLOT_W-1:0]  slot;
		logic               hit;
		logic               evicted;
		logic               last;
	} rsp_t;

	// One directory entry as it streams out of the tile store.
	typedef struct packed {
		logic               vld;
		logic               slot_valid;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] tz;
	} feed_t;

	typedef struct packed {
		logic hit;
		logic empty_found;
	} scan_stat_t;

endpackage

`default_nettype wire

@@ rtl/tcfe_ram.sv @@
// ============================================================================
// tcfe_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
`default_nettype none

module tcfe_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcfe_scan.sv @@
// ============================================================================
// tcfe_scan: directory scan accumulator
// Takes one directory entry per cycle and keeps the first hit, the lowest
// empty slot and the farthest valid entry seen since the last clear.
// ============================================================================
`default_nettype none

module tcfe_scan #(
	parameter int SLOTS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 clear,
	input  wire tcfe_pkg::feed_t                feed,
	input  wire [tcfe_pkg::COORD_W-1:0]         bx,
	input  wire [tcfe_pkg::COORD_W-1:0]         bz,
	output tcfe_pkg::scan_stat_t                stat,
	output logic [$clog2(SLOTS)-1:0]            hit_idx,
	output logic [$clog2(SLOTS)-1:0]            empty_idx,
	output logic [$clog2(SLOTS)-1:0]            victim_idx
);

	localparam int IDX_W = $clog2(SLOTS);

	tcfe_pkg::scan_stat_t             stat_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [IDX_W-1:0]                 hit_idx_q;
	logic [IDX_W-1:0]                 empty_idx_q;
	logic [IDX_W-1:0]                 victim_q;
	logic [tcfe_pkg::DIST_W-1:0]      best_q;
	logic [tcfe_pkg::COORD_W-1:0]     dx;
	logic [tcfe_pkg::COORD_W-1:0]     dz;
	logic [tcfe_pkg::DIST_W-1:0]      distance;
	logic                             match;

	always_comb begin
		dx       = (feed.tx > bx) ? (feed.tx - bx) : (bx - feed.tx);
		dz       = (feed.tz > bz) ? (feed.tz - bz) : (bz - feed.tz);
		distance = {1'b0, dx} + {1'b0, dz};
		match    = (feed.tx == bx) && (feed.tz == bz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q      <= '0;
			idx_q       <= '0;
			hit_idx_q   <= '0;
			empty_idx_q <= '0;
			victim_q    <= '0;
			best_q      <= '0;
		end else if (clear) begin
			stat_q   <= '0;
			idx_q    <= '0;
			victim_q <= '0;
			best_q   <= '0;
		end else if (feed.vld) begin
			idx_q <= idx_q + 1'b1;
			if (feed.slot_valid) begin
				if (!stat_q.hit && match) begin
					stat_q.hit <= 1'b1;
					hit_idx_q  <= idx_q;
				end
				// Strictly greater keeps the lowest index on a tie.
				if (distance > best_q) begin
					best_q   <= distance;
					victim_q <= idx_q;
				end
			end else if (!stat_q.empty_found) begin
				stat_q.empty_found <= 1'b1;
				empty_idx_q        <= idx_q;
			end
		end
	end

	assign stat       = stat_q;
	assign hit_idx    = hit_idx_q;
	assign empty_idx  = empty_idx_q;
	assign victim_idx = victim_q;

endmodule

`default_nettype wire

@@ rtl/tile_cache_farthest_evict.sv @@
// ============================================================================
// tile_cache_farthest_evict: fully associative tile directory
// Looks up the three by three neighborhood of a center tile, fills misses
// into the lowest empty slot or evicts the farthest tile, and flushes on
// request.
// ============================================================================
//
//  Channel   Handshake            Payload  Direction
//  -------   ---------            -------  ---------
//  command   start / busy         cmd      in: enter center tile or flush
//  result    rsp_valid (strobe)   rsp      out: one per looked-up tile
//
// An enter transaction with a valid center keeps busy high while each of
// the nine lookups streams every slot out of the tile store, one entry per
// cycle through its single read port, lets the last read land and commits.
// A flush, or an enter whose center lies off the grid, is finished in the
// cycle it is accepted and raises no busy.
// Reset clears every valid bit at once; the tile store itself is not reset.
// Results are strobed for one cycle and the receiver cannot stall them.
// ============================================================================
`default_nettype none

module tile_cache_farthest_evict #(
	parameter int CACHE_SLOTS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire tcfe_pkg::cmd_t cmd,
	output logic                rsp_valid,
	output tcfe_pkg::rsp_t      rsp
);

	localparam int IDX_W  = $clog2(CACHE_SLOTS);
	localparam int ENTRY_W = 2 * tcfe_pkg::COORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t                           state_q;
	logic [IDX_W-1:0]                 addr_q;
	logic [1:0]                       col_q;
	logic [1:0]                       row_q;
	logic [tcfe_pkg::GRID_W-1:0]      cx_q;
	logic [tcfe_pkg::GRID_W-1:0]      cz_q;
	logic [CACHE_SLOTS-1:0]           valid_q;
	logic                             rd_vld_s1;
	logic                             slot_valid_s1;
	logic                             rsp_valid_q;
	tcfe_pkg::rsp_t                   rsp_q;

	logic                             accept;
	logic                             in_range;
	logic                             rd_en;
	logic                             wr_en;
	logic [ENTRY_W-1:0]               rd_data;
	logic [tcfe_pkg::COORD_W-1:0]     bx;
	logic [tcfe_pkg::COORD_W-1:0]     bz;
	tcfe_pkg::feed_t                  feed;
	tcfe_pkg::scan_stat_t             stat;
	logic [IDX_W-1:0]                 hit_idx;
	logic [IDX_W-1:0]                 empty_idx;
	logic [IDX_W-1:0]                 victim_idx;
	logic [IDX_W-1:0]                 slot_sel;
	logic                             is_last;
	logic                             scan_clear;

	// -------------------------------------------------------------------
	// Command decode.
	// -------------------------------------------------------------------
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	// A center is on the grid when both coordinates are non-negative and
	// below the grid size, which is a power of two.
	assign in_range = (cmd.centre_x[7:tcfe_pkg::GRID_W] == '0)
		&& (cmd.centre_z[7:tcfe_pkg::GRID_W] == '0);

	// Biased coordinates of the tile under lookup: center - 1 + offset + 1.
	assign bx = {1'b0, cx_q} + tcfe_pkg::COORD_W'(col_q);
	assign bz = {1'b0, cz_q} + tcfe_pkg::COORD_W'(row_q);

	// -------------------------------------------------------------------
	// Tile store: one read per scan cycle, one write per committed miss.
	// The sequencer never reads and writes in the same cycle, and a write
	// in the commit cycle is visible to the first read of the next scan.
	// -------------------------------------------------------------------
	assign rd_en = (state_q == ST_SCAN);
	assign wr_en = (state_q == ST_COMMIT) && !stat.hit;

	tcfe_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CACHE_SLOTS)
	) u_tile_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_sel),
		.wdata ({bx, bz}),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	always_comb begin
		feed.vld        = rd_vld_s1;
		feed.slot_valid = slot_valid_s1;
		feed.tx         = rd_data[ENTRY_W-1:tcfe_pkg::COORD_W];
		feed.tz         = rd_data[tcfe_pkg::COORD_W-1:0];
	end

	// The accumulator starts afresh before every lookup.
	assign scan_clear = (state_q == ST_IDLE) || (state_q == ST_COMMIT);

	tcfe_scan #(
		.SLOTS (CACHE_SLOTS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (scan_clear),
		.feed       (feed),
		.bx         (bx),
		.bz         (bz),
		.stat       (stat),
		.hit_idx    (hit_idx),
		.empty_idx  (empty_idx),
		.victim_idx (victim_idx)
	);

	// Hit first, then the lowest empty slot, then the farthest entry.
	assign slot_sel = stat.hit ? hit_idx : (stat.empty_found ? empty_idx : victim_idx);
	assign is_last  = (row_q == tcfe_pkg::SPAN_LAST) && (col_q == tcfe_pkg::SPAN_LAST);

	// -------------------------------------------------------------------
	// Sequencer.
	// -------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			addr_q        <= '0;
			col_q         <= '0;
			row_q         <= '0;
			cx_q          <= '0;
			cz_q          <= '0;
			valid_q       <= '0;
			rd_vld_s1     <= 1'b0;
			slot_valid_s1 <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			rsp_valid_q   <= 1'b0;
			rd_vld_s1     <= rd_en;
			slot_valid_s1 <= valid_q[addr_q];
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.kind == tcfe_pkg::KIND_FLUSH) begin
							valid_q <= '0;
						end else if (in_range) begin
							cx_q    <= cmd.centre_x[tcfe_pkg::GRID_W-1:0];
							cz_q    <= cmd.centre_z[tcfe_pkg::GRID_W-1:0];
							col_q   <= '0;
							row_q   <= '0;
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IDX_W'(CACHE_SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					rsp_valid_q <= 1'b1;
					if (!stat.hit) begin
						valid_q[slot_sel] <= 1'b1;
					end
					addr_q <= '0;
					if (is_last) begin
						state_q <= ST_IDLE;
					end else begin
						if (col_q == tcfe_pkg::SPAN_LAST) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload, loaded in the commit cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			rsp_q.tile_x  <= $signed(8'({1'b0, bx}) - 8'd1);
			rsp_q.tile_z  <= $signed(8'({1'b0, bz}) - 8'd1);
			rsp_q.slot    <= slot_sel[tcfe_pkg::SLOT_W-1:0];
			rsp_q.hit     <= stat.hit;
			rsp_q.evicted <= !stat.hit && !stat.empty_found;
			rsp_q.last    <= is_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// -------------------------------------------------------------------
	// Assertions.
	// -------------------------------------------------------------------
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy))
		else $error("result strobed without a transaction in progress");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.evicted))
		else $error("a hit reported an eviction");

	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.evicted) |-> $past(&valid_q))
		else $error("eviction while an empty slot was available");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.kind == tcfe_pkg::KIND_FLUSH)) |=> (valid_q == '0))
		else $error("flush left a valid slot");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (rsp_valid && rsp.last))
		else $error("transaction ended without its last result");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ============================================================================
// tb: self-checking bench for tile_cache_farthest_evict
// A queue of commands feeds a clocked driver. A clocked monitor predicts every
// accepted transaction with its own copy of the tile directory and checks each
// strobed lookup result, field by field, in order of arrival.
// ============================================================================

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 16;
	localparam int GRID        = 64;
	// The drain after the last expected result allows for the whole busy
	// time of one valid enter.
	localparam int DRAIN       = 9 * (SLOTS + 2) + 16;
	localparam int TOTAL_ITEMS = 270;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	tcfe_pkg::cmd_t cmd = '0;
	logic busy;
	logic rsp_valid;
	tcfe_pkg::rsp_t rsp;

	// Commands still to be offered, and lookups predicted but not yet seen.
	tcfe_pkg::cmd_t pending_cmds [$];
	tcfe_pkg::rsp_t lookups_due  [$];

	// The bench's own copy of the tile directory, coordinates biased by one.
	bit       dir_valid [SLOTS];
	bit [6:0] dir_col   [SLOTS];
	bit [6:0] dir_row   [SLOTS];

	// Set at the rising edge that accepted a command, read at the next
	// falling edge so the driver knows it may present the next one.
	logic handed_over = 1'b0;

	int total_items;
	int accepted;
	int n_enter, n_flush, n_offgrid;
	int n_results, n_hits, n_evicts;
	int mismatches;

	tile_cache_farthest_evict #(.CACHE_SLOTS(SLOTS)) u_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.cmd,
		.rsp_valid,
		.rsp
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Look up one tile of the neighborhood, update the directory the way the
	// block does, and queue the result it must report.
	task automatic resolve_tile(input bit [6:0] bx, input bit [6:0] bz, input bit is_last);
		int   hit_idx;
		int   free_idx;
		int   victim;
		int   far;
		int   distance;
		int   slot;
		tcfe_pkg::rsp_t want;
		hit_idx = -1;
		free_idx = -1;
		want = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (dir_valid[i]) begin
				if (hit_idx < 0 && dir_col[i] == bx && dir_row[i] == bz)
					hit_idx = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit_idx >= 0) begin
			slot = hit_idx;
			want.hit = 1'b1;
			n_hits++;
		end else begin
			if (free_idx >= 0) begin
				slot = free_idx;
			end else begin
				// Every slot is in use: replace the farthest tile in Manhattan
				// distance, keeping the lowest index on a tie. Tiles filled
				// earlier in this same request are candidates as well.
				far = 0;
				victim = 0;
				for (int i = 0; i < SLOTS; i++) begin
					distance = (dir_col[i] > bx ? dir_col[i] - bx : bx - dir_col[i]) +
						(dir_row[i] > bz ? dir_row[i] - bz : bz - dir_row[i]);
					if (distance > far) begin
						far = distance;
						victim = i;
					end
				end
				slot = victim;
				want.evicted = 1'b1;
				n_evicts++;
			end
			dir_valid[slot] = 1'b1;
			dir_col[slot] = bx;
			dir_row[slot] = bz;
		end
		want.tile_x = 8'(int'(bx) - 1);
		want.tile_z = 8'(int'(bz) - 1);
		want.slot = tcfe_pkg::SLOT_W'(slot);
		want.last = is_last;
		lookups_due.push_back(want);
	endtask

	// Work out everything one accepted transaction does to the directory.
	task automatic predict_cmd(input tcfe_pkg::cmd_t c);
		if (c.kind == tcfe_pkg::KIND_FLUSH) begin
			n_flush++;
			for (int i = 0; i < SLOTS; i++)
				dir_valid[i] = 1'b0;
		end else if (c.centre_x < 0 || c.centre_x >= GRID ||
				c.centre_z < 0 || c.centre_z >= GRID) begin
			// A center off the grid is dropped without a result.
			n_offgrid++;
		end else begin
			n_enter++;
			// Rows are the outer loop and columns the inner one. With the
			// bias of one, the tiles run from the center to center + 2.
			for (int r = 0; r < tcfe_pkg::NEIGHBOUR_SPAN; r++)
				for (int k = 0; k < tcfe_pkg::NEIGHBOUR_SPAN; k++)
					resolve_tile(7'(int'(c.centre_x) + k), 7'(int'(c.centre_z) + r),
						r == tcfe_pkg::NEIGHBOUR_SPAN - 1 &&
						k == tcfe_pkg::NEIGHBOUR_SPAN - 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_lookup(input tcfe_pkg::rsp_t got);
		tcfe_pkg::rsp_t want;
		string bad;
		bad = "";
		if (lookups_due.size() == 0) begin
			report_mismatch($sformatf("result with nothing outstanding: tile (%0d,%0d) slot %0d",
				got.tile_x, got.tile_z, got.slot));
		end else begin
			want = lookups_due.pop_front();
			if (got.tile_x !== want.tile_x)
				bad = {bad, $sformatf(" tile_x exp %0d got %0d", want.tile_x, got.tile_x)};
			if (got.tile_z !== want.tile_z)
				bad = {bad, $sformatf(" tile_z exp %0d got %0d", want.tile_z, got.tile_z)};
			if (got.slot !== want.slot)
				bad = {bad, $sformatf(" slot exp %0d got %0d", want.slot, got.slot)};
			if (got.hit !== want.hit)
				bad = {bad, $sformatf(" hit exp %0b got %0b", want.hit, got.hit)};
			if (got.evicted !== want.evicted)
				bad = {bad, $sformatf(" evicted exp %0b got %0b", want.evicted, got.evicted)};
			if (got.last !== want.last)
				bad = {bad, $sformatf(" last exp %0b got %0b", want.last, got.last)};
			if (bad != "")
				report_mismatch($sformatf("tile (%0d,%0d):%s", want.tile_x, want.tile_z, bad));
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: changes inputs on the falling edge. A command stays on the bus
	// until the rising edge that accepts it; only then may the next one, or
	// an idle cycle, follow. The sender idles with a chance of 14 in a hundred
	// over the first third of the run, 66 over the second and never in the last.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || handed_over) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >=
					(accepted < total_items / 3 ? 14 :
					accepted < 2 * total_items / 3 ? 66 : 0)) begin
				start <= 1'b1;
				cmd   <= pending_cmds.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: samples on the rising edge, before the block's outputs move.
	// A result strobed now belongs to an earlier transaction, so it is
	// checked before a command accepted at this same edge is predicted.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid) begin
				n_results++;
				check_lookup(rsp);
			end
			if (start && !busy) begin
				accepted++;
				predict_cmd(cmd);
			end
		end
		handed_over <= arst_n && start && !busy;
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------

	function automatic void queue_cmd(input logic kind, input int x, input int z);
		tcfe_pkg::cmd_t c;
		c.kind = kind;
		c.centre_x = 8'(x);
		c.centre_z = 8'(z);
		pending_cmds.push_back(c);
	endfunction

	initial begin
		int pick;
		int walk_x;
		int walk_z;
		int ox;
		int oz;

		// Grid corners: neighbors fall off the grid to -1 and 64, and the
		// second corner already overflows the directory and forces evictions.
		queue_cmd(tcfe_pkg::KIND_ENTER, 0, 0);
		queue_cmd(tcfe_pkg::KIND_ENTER, 63, 63);
		queue_cmd(tcfe_pkg::KIND_ENTER, 63, 0);
		queue_cmd(tcfe_pkg::KIND_ENTER, 0, 63);
		// Centers just off the grid and at the extremes of the byte range.
		queue_cmd(tcfe_pkg::KIND_ENTER, -1, 0);
		queue_cmd(tcfe_pkg::KIND_ENTER, 64, 10);
		queue_cmd(tcfe_pkg::KIND_ENTER, 10, -128);
		queue_cmd(tcfe_pkg::KIND_ENTER, 127, 127);
		queue_cmd(tcfe_pkg::KIND_ENTER, 0, 64);
		queue_cmd(tcfe_pkg::KIND_ENTER, -128, -1);
		// A flush, then a refill into empty slots, a repeat that hits on
		// every tile, and a shift by one that mixes hits and fills.
		queue_cmd(tcfe_pkg::KIND_FLUSH, -128, 127);
		queue_cmd(tcfe_pkg::KIND_ENTER, 0, 63);
		queue_cmd(tcfe_pkg::KIND_ENTER, 0, 63);
		queue_cmd(tcfe_pkg::KIND_ENTER, 1, 63);
		queue_cmd(tcfe_pkg::KIND_FLUSH, 0, 0);
		// A tight walk keeps the directory full of nearby tiles, so that a
		// request may end up replacing tiles that it filled itself.
		queue_cmd(tcfe_pkg::KIND_ENTER, 30, 30);
		queue_cmd(tcfe_pkg::KIND_ENTER, 31, 30);
		queue_cmd(tcfe_pkg::KIND_ENTER, 30, 31);
		queue_cmd(tcfe_pkg::KIND_ENTER, 31, 31);
		queue_cmd(tcfe_pkg::KIND_ENTER, 31, 32);
		queue_cmd(tcfe_pkg::KIND_ENTER, 32, 33);
		queue_cmd(tcfe_pkg::KIND_ENTER, 33, 34);
		queue_cmd(tcfe_pkg::KIND_ENTER, 34, 33);
		queue_cmd(tcfe_pkg::KIND_FLUSH, 127, -128);

		// Random part: mostly a camera-like walk of the center with an
		// occasional jump, some flushes, and some centers off the grid.
		walk_x = $urandom_range(GRID - 1);
		walk_z = $urandom_range(GRID - 1);
		while (pending_cmds.size() < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				queue_cmd(tcfe_pkg::KIND_FLUSH, $urandom_range(255), $urandom_range(255));
			end else if (pick < 12) begin
				ox = $urandom_range(255);
				oz = $urandom_range(255);
				if (ox < GRID && oz < GRID)
					ox = ox | (64 << $urandom_range(1));
				queue_cmd(tcfe_pkg::KIND_ENTER, ox, oz);
			end else begin
				if (pick < 20) begin
					walk_x = $urandom_range(3) == 0 ? ($urandom_range(1) ? GRID - 1 : 0)
						: $urandom_range(GRID - 1);
					walk_z = $urandom_range(GRID - 1);
				end else begin
					walk_x += int'($urandom_range(4)) - 2;
					walk_z += int'($urandom_range(4)) - 2;
				end
				walk_x = walk_x < 0 ? 0 : (walk_x > GRID - 1 ? GRID - 1 : walk_x);
				walk_z = walk_z < 0 ? 0 : (walk_z > GRID - 1 ? GRID - 1 : walk_z);
				queue_cmd(tcfe_pkg::KIND_ENTER, walk_x, walk_z);
			end
		end
		total_items = pending_cmds.size();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Every command accepted, every predicted lookup seen, then a quiet
		// stretch long enough for one more full pass to show up if it exists.
		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (lookups_due.size() != 0)
			report_mismatch($sformatf("%0d lookups never reported", lookups_due.size()));

		$display("Ran %0d transactions: %0d enters, %0d flushes, %0d off-grid centers.",
			accepted, n_enter, n_flush, n_offgrid);
		$display("Checked %0d lookups (%0d hits, %0d evictions), %0d mismatches.",
			n_results, n_hits, n_evicts, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run of this stimulus.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/tcfe_pkg.sv
rtl/tcfe_ram.sv
rtl/tcfe_scan.sv
rtl/tile_cache_farthest_evict.sv
sim/tb.sv
